@@ sv/aarr_pkg.sv @@
// Package for the axis angle rotation rate core.
// Holds item types, pipeline payload types, fixed-point constants and the atan table.
package aarr_pkg;

  localparam int VEC_W = 28;   // CORDIC vector width (Q1.14 widened by 8 fraction bits)
  localparam int ANG_W = 17;   // angle accumulator, Q3.13 with headroom
  localparam int MAG_W = 15;   // |angle difference| < pi
  localparam int QUO_W = 28;   // speed magnitude, unsigned Q.20
  localparam int SUM_W = 44;   // rounded dividend width
  localparam int DIV_STAGES = QUO_W;

  localparam logic signed [ANG_W-1:0] ANG_PI      = 17'sd25736;
  localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 17'sd12868;
  localparam logic [MAG_W-1:0]        ANG_QTR_PI  = 15'd6434;
  localparam logic [15:0]             GAIN_RESET  = 16'd256;

  typedef struct packed {
    logic signed [15:0] cur_x;
    logic signed [15:0] cur_y;
    logic signed [15:0] tgt_x;
    logic signed [15:0] tgt_y;
  } in_t;

  typedef struct packed {
    logic signed [31:0] rate_x;
    logic signed [31:0] rate_y;
  } out_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [ANG_W-1:0] z;
    logic                    zero;   // direction was (0,0): angle forced to 0
  } vec_t;

  typedef struct packed {
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    vec_t               a;          // current direction
    vec_t               b;          // target direction
  } cor_t;

  typedef struct packed {
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic               neg;        // angle difference below zero
    logic [MAG_W-1:0]   den;
    logic [MAG_W-1:0]   rem;
    logic [QUO_W-1:0]   dq;         // dividend bits shifting out, quotient bits in
  } div_t;

  // atan(2^-i) in Q3.13
  function automatic logic signed [ANG_W-1:0] atan_q13(input int i);
    logic signed [ANG_W-1:0] v;
    unique case (i)
      0:       v = 17'sd6434;
      1:       v = 17'sd3798;
      2:       v = 17'sd2007;
      3:       v = 17'sd1019;
      4:       v = 17'sd511;
      5:       v = 17'sd256;
      6:       v = 17'sd128;
      7:       v = 17'sd64;
      8:       v = 17'sd32;
      9:       v = 17'sd16;
      10:      v = 17'sd8;
      11:      v = 17'sd4;
      12:      v = 17'sd2;
      13:      v = 17'sd1;
      default: v = 17'sd0;
    endcase
    return v;
  endfunction

endpackage

@@ sv/aarr_cordic_cell.sv @@
// One CORDIC vectoring cell, rotating the current and target vectors together.
// Depends on aarr_pkg.
module aarr_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_vld,
  input  aarr_pkg::cor_t in_d,
  output logic          out_vld,
  output aarr_pkg::cor_t out_d
);

  logic           vld_r;
  aarr_pkg::cor_t d_r, d_nxt;

  function automatic aarr_pkg::vec_t rot(input aarr_pkg::vec_t v);
    aarr_pkg::vec_t r;
    r = v;
    if (v.y >= 0) begin
      r.x = v.x + (v.y >>> STAGE);
      r.y = v.y - (v.x >>> STAGE);
      r.z = v.z + aarr_pkg::atan_q13(STAGE);
    end else begin
      r.x = v.x - (v.y >>> STAGE);
      r.y = v.y + (v.x >>> STAGE);
      r.z = v.z - aarr_pkg::atan_q13(STAGE);
    end
    return r;
  endfunction

  // micro-rotation of both vectors
  always_comb begin
    d_nxt    = in_d;
    d_nxt.a  = rot(in_d.a);
    d_nxt.b  = rot(in_d.b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    d_r <= d_nxt;
  end

  assign out_vld = vld_r;
  assign out_d   = d_r;

endmodule

@@ sv/aarr_div_cell.sv @@
// One restoring-division cell: yields one speed quotient bit per cycle.
// Depends on aarr_pkg.
module aarr_div_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_vld,
  input  aarr_pkg::div_t in_d,
  output logic          out_vld,
  output aarr_pkg::div_t out_d
);

  logic                     vld_r;
  aarr_pkg::div_t           d_r, d_nxt;
  logic [aarr_pkg::MAG_W:0] rem2;
  logic                     ge;

  // shift in next dividend bit, trial subtract
  always_comb begin
    rem2  = {in_d.rem, in_d.dq[aarr_pkg::QUO_W-1]};
    ge    = (rem2 >= {1'b0, in_d.den});
    d_nxt = in_d;
    if (ge) begin
      d_nxt.rem = aarr_pkg::MAG_W'(rem2 - {1'b0, in_d.den});
    end else begin
      d_nxt.rem = rem2[aarr_pkg::MAG_W-1:0];
    end
    d_nxt.dq = {in_d.dq[aarr_pkg::QUO_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    d_r <= d_nxt;
  end

  assign out_vld = vld_r;
  assign out_d   = d_r;

endmodule

@@ sv/axis_angle_rotation_rate_2d_core.sv @@
// Axis angle rotation rate core: fully registered pipeline from start to out_valid.
// Throughput one item per cycle; busy is always low, so start may be held every cycle.
// Depth is set by the CORDIC cell chain plus 28 divider cells (one speed bit each).
// Synchronous active-low reset clears all valid flags and sets gain_r to 1.0 (Q8.8).
// Results are strobed on out_valid for one cycle; the receiver cannot stall.
module axis_angle_rotation_rate_2d_core #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  aarr_pkg::in_t  in_item,
  input  logic           cfg_wr_en,
  input  logic [15:0]    cfg_wr_data,
  output logic           out_valid,
  output aarr_pkg::out_t out_item
);

  localparam int VW = aarr_pkg::VEC_W;
  localparam int AW = aarr_pkg::ANG_W;
  localparam int MW = aarr_pkg::MAG_W;
  localparam int QW = aarr_pkg::QUO_W;
  localparam int SW = aarr_pkg::SUM_W;

  assign busy = 1'b0;

  // gain register
  logic [15:0] gain_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= aarr_pkg::GAIN_RESET;
    end else if (cfg_wr_en) begin
      gain_r <= cfg_wr_data;
    end
  end

  // input capture: widen, fold into right half plane
  function automatic aarr_pkg::vec_t prep(input logic signed [15:0] x,
                                          input logic signed [15:0] y);
    aarr_pkg::vec_t v;
    logic signed [VW-1:0] wx, wy;
    wx     = VW'(x) <<< 8;
    wy     = VW'(y) <<< 8;
    v.zero = (x == 16'sd0) && (y == 16'sd0);
    v.z    = '0;
    if (x < 0) begin
      v.x = -wx;
      v.y = -wy;
    end else begin
      v.x = wx;
      v.y = wy;
    end
    return v;
  endfunction

  logic           s0_vld_r;
  aarr_pkg::cor_t s0_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= start && !busy;
    end
  end
  always_ff @(posedge clk) begin
    s0_r.cx <= in_item.cur_x;
    s0_r.cy <= in_item.cur_y;
    s0_r.a  <= prep(in_item.cur_x, in_item.cur_y);
    s0_r.b  <= prep(in_item.tgt_x, in_item.tgt_y);
  end

  // CORDIC cell chain
  logic           cor_vld [CORDIC_STAGES+1];
  aarr_pkg::cor_t cor_d   [CORDIC_STAGES+1];
  assign cor_vld[0] = s0_vld_r;
  assign cor_d[0]   = s0_r;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cor
    aarr_cordic_cell #(.STAGE(g)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_vld  (cor_vld[g]),
      .in_d    (cor_d[g]),
      .out_vld (cor_vld[g+1]),
      .out_d   (cor_d[g+1])
    );
  end

  // fold to axis angle and take difference
  function automatic logic signed [AW-1:0] fold(input aarr_pkg::vec_t v);
    logic signed [AW-1:0] z;
    z = v.z;
    if (z > aarr_pkg::ANG_HALF_PI) z = z - aarr_pkg::ANG_PI;
    if (z <= -aarr_pkg::ANG_HALF_PI) z = z + aarr_pkg::ANG_PI;
    if (v.zero) z = '0;
    return z;
  endfunction

  aarr_pkg::cor_t       cor_last;
  logic signed [AW-1:0] diff;
  assign cor_last = cor_d[CORDIC_STAGES];
  assign diff     = fold(cor_last.b) - fold(cor_last.a);

  logic               f_vld_r;
  logic signed [15:0] f_cx_r, f_cy_r;
  logic               f_neg_r;
  logic [MW-1:0]      f_mag_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else begin
      f_vld_r <= cor_vld[CORDIC_STAGES];
    end
  end
  always_ff @(posedge clk) begin
    f_cx_r  <= cor_last.cx;
    f_cy_r  <= cor_last.cy;
    f_neg_r <= diff < 0;
    f_mag_r <= (diff < 0) ? MW'(-diff) : MW'(diff);
  end

  // gain multiply, divisor and rounded dividend
  logic [MW-1:0]  den;
  logic [30:0]    kmag;
  logic [SW-1:0]  sum;
  assign den  = aarr_pkg::ANG_QTR_PI + f_mag_r;
  assign kmag = 31'(gain_r) * 31'(f_mag_r);
  assign sum  = (SW'(kmag) << 12) + SW'(den >> 1);

  logic           dv_vld [aarr_pkg::DIV_STAGES+1];
  aarr_pkg::div_t dv_d   [aarr_pkg::DIV_STAGES+1];
  logic           m_vld_r;
  aarr_pkg::div_t m_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else begin
      m_vld_r <= f_vld_r;
    end
  end
  always_ff @(posedge clk) begin
    m_r.cx  <= f_cx_r;
    m_r.cy  <= f_cy_r;
    m_r.neg <= f_neg_r;
    m_r.den <= den;
    m_r.rem <= sum[QW+MW-1:QW];   // quotient < 2^28 keeps this below den
    m_r.dq  <= sum[QW-1:0];
  end
  assign dv_vld[0] = m_vld_r;
  assign dv_d[0]   = m_r;

  // divider cell chain
  for (genvar g = 0; g < aarr_pkg::DIV_STAGES; g++) begin : g_div
    aarr_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_vld  (dv_vld[g]),
      .in_d    (dv_d[g]),
      .out_vld (dv_vld[g+1]),
      .out_d   (dv_d[g+1])
    );
  end

  // signed speed times component
  aarr_pkg::div_t     dv_last;
  logic signed [QW:0] speed;
  logic signed [16:0] comp_x, comp_y;
  assign dv_last = dv_d[aarr_pkg::DIV_STAGES];
  assign speed   = dv_last.neg ? -$signed({1'b0, dv_last.dq}) : $signed({1'b0, dv_last.dq});
  assign comp_x  = -(17'(dv_last.cy));
  assign comp_y  = 17'(dv_last.cx);

  localparam int PW = QW + 18;
  logic              p_vld_r;
  logic signed [PW-1:0] px_r, py_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else begin
      p_vld_r <= dv_vld[aarr_pkg::DIV_STAGES];
    end
  end
  always_ff @(posedge clk) begin
    px_r <= PW'(comp_x) * PW'(speed);
    py_r <= PW'(comp_y) * PW'(speed);
  end

  // round, shift, saturate
  function automatic logic signed [31:0] rnd_sat(input logic signed [PW-1:0] p);
    logic signed [PW:0]    t;
    logic signed [PW-14:0] s;
    t = (PW+1)'(p) + (PW+1)'(8192);
    s = t[PW:14];
    if (s > (PW-13)'(32'sh7fffffff)) return 32'sh7fffffff;
    if (s < -(PW-13)'(33'sh080000000)) return 32'sh80000000;
    return s[31:0];
  endfunction

  logic           o_vld_r;
  aarr_pkg::out_t o_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else begin
      o_vld_r <= p_vld_r;
    end
  end
  always_ff @(posedge clk) begin
    o_r.rate_x <= rnd_sat(px_r);
    o_r.rate_y <= rnd_sat(py_r);
  end

  assign out_valid = o_vld_r;
  assign out_item  = o_r;

endmodule

@@ sv/aarr_checker.sv @@
// Port-level checker for the rotation rate core, bound to the top level.
// Depends on aarr_pkg and axis_angle_rotation_rate_2d_core.
module aarr_checker #(
  parameter int CORDIC_STAGES = 16
) (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input aarr_pkg::in_t  in_item,
  input logic           out_valid,
  input aarr_pkg::out_t out_item
);

  localparam int LAT = CORDIC_STAGES + 33;

  // core never refuses an item
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  // each accepted item gives one result after a fixed latency
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("missing result");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    !start |-> ##LAT !out_valid)
    else $error("result without item");

  // equal directions give zero rate
  a_same_dir: assert property (@(posedge clk) disable iff (!rst_n)
    (start && in_item.cur_x == in_item.tgt_x && in_item.cur_y == in_item.tgt_y)
      |-> ##LAT (out_item.rate_x == 32'sd0 && out_item.rate_y == 32'sd0))
    else $error("nonzero rate for equal directions");

endmodule

bind axis_angle_rotation_rate_2d_core aarr_checker #(.CORDIC_STAGES(CORDIC_STAGES)) u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_item  (out_item)
);

@@ test/axis_angle_rotation_rate_2d_core_tb.sv @@
// Testbench for the axis angle rotation rate core: directed and random items,
// predicted in-line by a fixed-point CORDIC and divider model. Depends on aarr_pkg.
module axis_angle_rotation_rate_2d_core_tb;

  localparam int STAGES = 16;
  localparam int LATENCY = STAGES + 33;
  localparam int MAX_CYCLES = 400000;

  logic clk, rst_n;
  logic start, busy;
  aarr_pkg::in_t in_item;
  logic cfg_wr_en;
  logic [15:0] cfg_wr_data;
  logic out_valid;
  aarr_pkg::out_t out_item;

  axis_angle_rotation_rate_2d_core #(.CORDIC_STAGES(STAGES)) uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .out_valid(out_valid), .out_item(out_item)
  );

  // clock
  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  aarr_pkg::in_t pending_items[$];
  aarr_pkg::out_t expected_rates[$];
  logic [15:0] gain;
  int idle_pct;
  int errors;
  longint cycles;

  // error report
  task automatic report(input string msg);
    $display("ERROR: %s", msg);
    errors++;
  endtask

  // angle of (x,y) in Q3.13, folded to an axis
  function automatic longint axis_of(input longint x, input longint y);
    longint z, nx, ny;
    longint atan_tab[14] = '{6434, 3798, 2007, 1019, 511, 256, 128, 64, 32, 16, 8, 4, 2, 1};
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      x = -x;
      y = -y;
    end
    x = x * 256;
    y = y * 256;
    for (int i = 0; i < STAGES; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        if (i < 14) z += atan_tab[i];
      end else begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        if (i < 14) z -= atan_tab[i];
      end
      x = nx;
      y = ny;
    end
    if (z > 12868) z -= 25736;
    if (z <= -12868) z += 25736;
    return z;
  endfunction

  function automatic logic [31:0] scaled(input longint c, input longint sp);
    longint p;
    p = (c * sp + 8192) >>> 14;
    if (p > 64'sd2147483647) p = 64'sd2147483647;
    if (p < -64'sd2147483648) p = -64'sd2147483648;
    return p[31:0];
  endfunction

  function automatic aarr_pkg::out_t rotation_rate(input aarr_pkg::in_t it);
    longint a, mag, den, sp, cx, cy;
    aarr_pkg::out_t r;
    cx = it.cur_x;
    cy = it.cur_y;
    a = axis_of(it.tgt_x, it.tgt_y) - axis_of(cx, cy);
    mag = (a < 0) ? -a : a;
    den = 6434 + mag;
    sp = ((longint'(gain) * mag * 4096) + den / 2) / den;
    if (a < 0) sp = -sp;
    r.rate_x = scaled(-cy, sp);
    r.rate_y = scaled(cx, sp);
    return r;
  endfunction

  // driver: presents queued items, idling at random
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_rates.push_back(rotation_rate(in_item));
        void'(pending_items.pop_front());
      end
      if (!(start && busy)) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
          start <= 1'b1;
          in_item <= pending_items[0];
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result with the oldest expectation
  always @(posedge clk) begin
    aarr_pkg::out_t e;
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end else if (rst_n && out_valid) begin
      if (expected_rates.size() == 0) begin
        report("result with nothing expected");
      end else begin
        e = expected_rates.pop_front();
        if (out_item.rate_x !== e.rate_x)
          report($sformatf("rate_x %0d, expected %0d", out_item.rate_x, e.rate_x));
        if (out_item.rate_y !== e.rate_y)
          report($sformatf("rate_y %0d, expected %0d", out_item.rate_y, e.rate_y));
      end
    end
  end

  function automatic aarr_pkg::in_t rand_item();
    aarr_pkg::in_t it;
    it = aarr_pkg::in_t'({$urandom, $urandom});
    if ($urandom_range(9) == 0) it.cur_x = 0;
    if ($urandom_range(9) == 0) it.cur_y = 0;
    if ($urandom_range(19) == 0) it.tgt_x = 0;
    if ($urandom_range(19) == 0) it.tgt_y = 0;
    return it;
  endfunction

  task automatic drain();
    while (pending_items.size() > 0 || start || expected_rates.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_gain(input logic [15:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    gain = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    logic signed [15:0] ext[6] = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'sh4000, 16'shc000, 16'sh0001};
    logic [15:0] gains[5] = '{16'd256, 16'hffff, 16'd0, 16'd1, 16'h1234};
    int pct[4] = '{0, 75, 0, 33};
    aarr_pkg::in_t it;
    errors = 0;
    cycles = 0;
    gain = aarr_pkg::GAIN_RESET;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    idle_pct = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    // directed: extremes, zero vectors, opposite and right-angle axes (reset gain)
    for (int i = 0; i < 6; i++) begin
      it.cur_x = ext[i]; it.cur_y = ext[(i + 1) % 6];
      it.tgt_x = ext[(i + 3) % 6]; it.tgt_y = ext[(i + 4) % 6];
      pending_items.push_back(it);
    end
    pending_items.push_back('{16'sh7fff, 16'sh0000, 16'sh0000, 16'sh7fff});
    pending_items.push_back('{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff});
    pending_items.push_back('{16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000});
    pending_items.push_back('{16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000});
    drain();
    // random phases over several gains, including extremes
    for (int g = 0; g < 5; g++) begin
      write_gain(g == 4 ? 16'($urandom) : gains[g]);
      for (int p = 0; p < 4; p++) begin
        idle_pct = pct[p];
        for (int n = 0; n < 52; n++) pending_items.push_back(rand_item());
        if (p == 1) drain();
        while (pending_items.size() > 0) @(posedge clk);
      end
      drain();
    end
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
